// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LPSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpsp assertion failed");

// Checked on every edge, reset included.
`define LPSP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lpsp assertion failed");

`endif

// ===== rtl/core/lpsp_pkg.sv =====
package lpsp_pkg;

  localparam int WORD_W       = 32;
  localparam int PIXEL_W      = 24;
  localparam int SYMS_PER_PIX = 3 * PIXEL_W;

  localparam logic       FUNC_PIXEL    = 1'b0;
  localparam logic       FUNC_EOF      = 1'b1;
  localparam logic [2:0] SILENCE_WORDS = 3'd6;
  localparam logic [15:0] CAP_RESET    = 16'd1024;

  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic              three;
    logic [WORD_W-1:0] next_partial;
    logic [4:0]        next_fill;
  } slice_t;

  // Each data bit b, MSB first, becomes the symbols 1, b, 0.
  function automatic logic [SYMS_PER_PIX-1:0] expand_symbols(input logic [PIXEL_W-1:0] px);
    logic [SYMS_PER_PIX-1:0] syms;
    syms = '0;
    for (int i = 0; i < PIXEL_W; i++) begin
      syms[SYMS_PER_PIX-1-3*i -: 3] = {1'b1, px[PIXEL_W-1-i], 1'b0};
    end
    return syms;
  endfunction

endpackage

// ===== rtl/core/led_pixel_symbol_packer.sv =====
// LED pixel symbol packer.
// Input channel (in_valid/in_ready): one request per pixel (in_func = 0, with
// green, red, blue bytes) or per end of frame (in_func = 1). Each data bit is
// line coded as three symbols and packed MSB first into 32-bit words.
// Output channel (out_valid/out_ready): one result per transfer; out_last marks
// the final word caused by an input request, out_frame_done the final result
// of an end of frame, which flushes the partial word and up to six zero words.
// cfg_wr_en/cfg_wr_data write the per-frame word capacity (reset 1024).
// A request passes the input register, then the result register, which holds
// its first result. Throughput: the result register sends one word per cycle
// while out_ready is high, so a pixel gives 2 or 3 words (fewer once capacity
// is reached), an end of frame up to 7; a pixel dropped while the frame is
// full gives no result. The next request is loaded as the last word leaves.
// Reset (rst_n low, synchronous) empties both registers and clears the frame.
// A stalled receiver holds the current word; the input register fills and
// in_ready drops until results move again.
module led_pixel_symbol_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_has_word,
  output logic        out_last,
  output logic        out_frame_done,
  output logic [15:0] out_words_used,
  output logic        out_buffer_full
);

  logic [15:0] cap_r;

  logic        s1_valid_r;
  logic        s1_func_r;
  logic [23:0] s1_pix_r;

  logic [4:0]  fill_r;
  logic [31:0] partial_r;
  logic [15:0] count_r;
  logic        full_r;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [31:0] next1_r;
  logic [31:0] next2_r;
  logic        has_word_r;
  logic [2:0]  rem_r;
  logic [15:0] used_r;
  logic        job_eof_r;
  logic        job_full_r;

  lpsp_pkg::slice_t slice;

  logic        is_eof;
  logic        job_free;
  logic        drop;
  logic        s1_take;
  logic        load;
  logic [2:0]  nw;
  logic [17:0] room;
  logic        stop;
  logic [2:0]  results;
  logic        advance;

  lpsp_slicer u_slicer (
    .partial (partial_r),
    .fill    (fill_r),
    .pixel   (s1_pix_r),
    .slice   (slice)
  );

  always_comb begin
    is_eof   = (s1_func_r == lpsp_pkg::FUNC_EOF);
    job_free = !out_valid_r || (out_ready && out_last);
    drop     = !is_eof && full_r;
    s1_take  = s1_valid_r && (drop || job_free);
    load     = s1_take && !drop;
    in_ready = !s1_valid_r || s1_take;
    advance  = out_valid_r && out_ready && !out_last;

    if (is_eof) begin
      nw = lpsp_pkg::SILENCE_WORDS + 3'd1;
    end else begin
      nw = slice.three ? 3'd3 : 3'd2;
    end
    // Words left before capacity, minus one: negative means full after one word.
    room = {2'b0, cap_r} - {2'b0, count_r} - 18'd1;
    stop = room[17] || (room[16:0] < {14'b0, nw});
    if (room[17]) begin
      results = 3'd1;
    end else if (stop) begin
      results = room[2:0] + 3'd1;
    end else begin
      results = nw;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_has_word    = has_word_r;
  assign out_last        = (rem_r == 3'd0);
  assign out_frame_done  = out_last && job_eof_r;
  assign out_buffer_full = out_last && job_full_r;
  assign out_words_used  = used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lpsp_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func_r <= in_func;
      s1_pix_r  <= {in_green, in_red, in_blue};
    end
  end

  // Frame state advances when a request is loaded into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      partial_r <= '0;
      count_r   <= '0;
      full_r    <= 1'b0;
    end else if (load) begin
      if (is_eof) begin
        fill_r    <= '0;
        partial_r <= '0;
        count_r   <= '0;
        full_r    <= 1'b0;
      end else if (stop) begin
        fill_r    <= '0;
        partial_r <= '0;
        count_r   <= count_r + {13'b0, results};
        full_r    <= 1'b1;
      end else begin
        fill_r    <= slice.next_fill;
        partial_r <= slice.next_partial;
        count_r   <= count_r + {13'b0, results};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready && out_last) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_eof_r <= is_eof;
      if (is_eof && full_r) begin
        out_word_r <= '0;
        next1_r    <= '0;
        next2_r    <= '0;
        has_word_r <= 1'b0;
        rem_r      <= '0;
        used_r     <= count_r;
        job_full_r <= 1'b1;
      end else begin
        out_word_r <= is_eof ? partial_r : slice.word0;
        next1_r    <= is_eof ? '0 : slice.word1;
        next2_r    <= is_eof ? '0 : slice.word2;
        has_word_r <= 1'b1;
        rem_r      <= results - 3'd1;
        used_r     <= count_r + 16'd1;
        job_full_r <= stop;
      end
    end else if (advance) begin
      out_word_r <= next1_r;
      next1_r    <= next2_r;
      next2_r    <= '0;
      rem_r      <= rem_r - 3'd1;
      used_r     <= used_r + 16'd1;
    end
  end

endmodule

// ===== rtl/core/lpsp_slicer.sv =====
module lpsp_slicer (
  input  logic [lpsp_pkg::WORD_W-1:0]  partial,
  input  logic [4:0]                   fill,
  input  logic [lpsp_pkg::PIXEL_W-1:0] pixel,
  output lpsp_pkg::slice_t             slice
);

  localparam int STREAM_W = lpsp_pkg::WORD_W + lpsp_pkg::SYMS_PER_PIX;

  logic [lpsp_pkg::SYMS_PER_PIX-1:0] syms;
  logic [STREAM_W-1:0]               stream;

  // Left-align held symbols, then append the 72 new ones right behind them.
  always_comb begin
    syms   = lpsp_pkg::expand_symbols(pixel);
    stream = {partial, {lpsp_pkg::SYMS_PER_PIX{1'b0}}}
           | ({syms, {lpsp_pkg::WORD_W{1'b0}}} >> fill);
    slice.word0 = stream[103:72];
    slice.word1 = stream[71:40];
    slice.three = (fill >= 5'd24);
    if (slice.three) begin
      slice.word2        = stream[39:8];
      slice.next_partial = {stream[7:0], 24'b0};
      slice.next_fill    = fill - 5'd24;
    end else begin
      slice.word2        = '0;
      slice.next_partial = stream[39:8];
      slice.next_fill    = fill + 5'd8;
    end
  end

endmodule

// ===== rtl/core/lpsp_checker.sv =====
`include "assert_macros.svh"

module lpsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        out_has_word,
  input logic        out_last,
  input logic        out_frame_done,
  input logic [15:0] out_words_used,
  input logic        out_buffer_full
);

  `LPSP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)
  `LPSP_ASSERT(a_done_is_last, out_valid && out_frame_done |-> out_last)
  `LPSP_ASSERT(a_full_is_last, out_valid && out_buffer_full |-> out_last)
  `LPSP_ASSERT(a_status_only,
    out_valid && !out_has_word |-> out_frame_done && out_buffer_full)
  `LPSP_ASSERT(a_stall_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_words_used))

endmodule

bind led_pixel_symbol_packer lpsp_checker u_lpsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_word        (out_word),
  .out_has_word    (out_has_word),
  .out_last        (out_last),
  .out_frame_done  (out_frame_done),
  .out_words_used  (out_words_used),
  .out_buffer_full (out_buffer_full)
);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RESULTS  = 7;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PRINT_LIMIT  = 50;
  localparam int ITEMS_PER_PHASE = 45;

  typedef struct packed {
    logic [lpsp_pkg::WORD_W-1:0] word;
    logic                        has_word;
    logic                        last;
    logic                        frame_done;
    logic [15:0]                 words_used;
    logic                        buffer_full;
  } symbol_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } stall_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = lpsp_pkg::FUNC_PIXEL;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_word;
  logic        out_has_word;
  logic        out_last;
  logic        out_frame_done;
  logic [15:0] out_words_used;
  logic        out_buffer_full;

  // Predicted frame state and capacity register.
  logic [4:0]                  slot = 5'd31;
  logic [lpsp_pkg::WORD_W-1:0] gather = '0;
  logic [15:0]                 frame_words = '0;
  logic                        frame_full = 1'b0;
  logic [15:0]                 capacity = lpsp_pkg::CAP_RESET;

  symbol_result_t batch [0:MAX_RESULTS-1];
  int             batch_n;
  symbol_result_t expected_words [$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;

  bit          hold_arm = 1'b0;
  int          hold_left = 0;
  stall_mode_t stall_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          period_cnt = 0;

  led_pixel_symbol_packer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_green        (in_green),
    .in_red          (in_red),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_has_word    (out_has_word),
    .out_last        (out_last),
    .out_frame_done  (out_frame_done),
    .out_words_used  (out_words_used),
    .out_buffer_full (out_buffer_full)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_result(input logic [lpsp_pkg::WORD_W-1:0] w,
                                     input logic has);
    batch[batch_n].word        = w;
    batch[batch_n].has_word    = has;
    batch[batch_n].last        = 1'b0;
    batch[batch_n].frame_done  = 1'b0;
    batch[batch_n].words_used  = frame_words;
    batch[batch_n].buffer_full = frame_full;
    batch_n++;
  endfunction

  // Fullness is tested only after a word goes out.
  function automatic void emit_word(input logic [lpsp_pkg::WORD_W-1:0] w);
    frame_words = frame_words + 16'd1;
    if (frame_words >= capacity)
      frame_full = 1'b1;
    add_result(w, 1'b1);
  endfunction

  function automatic bit place_symbol(input logic s);
    gather[slot] = s;
    if (slot == 5'd0) begin
      emit_word(gather);
      slot = 5'd31;
      gather = '0;
      if (frame_full)
        return 1'b0;
    end else begin
      slot = slot - 5'd1;
    end
    return 1'b1;
  endfunction

  function automatic bit place_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) begin
      if (!place_symbol(1'b1)) return 1'b0;
      if (!place_symbol(v[i])) return 1'b0;
      if (!place_symbol(1'b0)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_request(input logic func, input logic [7:0] g,
                                          input logic [7:0] r, input logic [7:0] b);
    batch_n = 0;
    if (func == lpsp_pkg::FUNC_PIXEL) begin
      if (!frame_full) begin
        if (place_byte(g))
          if (place_byte(r))
            void'(place_byte(b));
        if (batch_n > 0)
          batch[batch_n-1].last = 1'b1;
      end
    end else begin
      if (frame_full) begin
        add_result('0, 1'b0);
      end else begin
        emit_word(gather);
        for (int k = 0; k < lpsp_pkg::SILENCE_WORDS && !frame_full; k++)
          emit_word('0);
      end
      batch[batch_n-1].last = 1'b1;
      batch[batch_n-1].frame_done = 1'b1;
      slot = 5'd31;
      gather = '0;
      frame_words = '0;
      frame_full = 1'b0;
    end
    for (int i = 0; i < batch_n; i++)
      expected_words.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : check_results
    symbol_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report($sformatf("result with nothing expected, word %h", out_word));
      end else begin
        want = expected_words.pop_front();
        if (out_word !== want.word)
          report($sformatf("word %h, want %h", out_word, want.word));
        if (out_has_word !== want.has_word)
          report($sformatf("has_word %b, want %b", out_has_word, want.has_word));
        if (out_last !== want.last)
          report($sformatf("last %b, want %b", out_last, want.last));
        if (out_frame_done !== want.frame_done)
          report($sformatf("frame_done %b, want %b", out_frame_done, want.frame_done));
        if (out_words_used !== want.words_used)
          report($sformatf("words_used %0d, want %0d", out_words_used, want.words_used));
        if (out_buffer_full !== want.buffer_full)
          report($sformatf("buffer_full %b, want %b", out_buffer_full, want.buffer_full));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    period_cnt++;
    if (hold_arm) begin
      hold_left = LONG_HOLD;
      hold_arm = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= (period_cnt % 5) != 0;
      endcase
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_request(input logic func, input logic [7:0] g,
                              input logic [7:0] r, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_green <= g;
    in_red   <= r;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    predict_request(func, g, r, b);
  endtask

  task automatic send_pixel(input logic [7:0] g, input logic [7:0] r, input logic [7:0] b);
    send_request(lpsp_pkg::FUNC_PIXEL, g, r, b);
  endtask

  task automatic send_end_of_frame();
    send_request(lpsp_pkg::FUNC_EOF, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, drain all results, then allow for a dropped pixel still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_words();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'ha5, 8'h5a, 8'h0f);
    send_end_of_frame();
    // empty frame: flush of an untouched partial word
    send_end_of_frame();
    send_pixel(8'h80, 8'h01, 8'hff);
    send_pixel(8'h01, 8'h80, 8'h00);
    send_end_of_frame();
  endtask

  task automatic test_capacity_stops();
    // full on the first word, then a dropped pixel and a status-only end
    write_capacity(16'd1);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_end_of_frame();
    // capacity reached in the middle of a pixel
    write_capacity(16'd3);
    send_pixel(8'hc3, 8'h3c, 8'h99);
    send_pixel(8'h66, 8'h81, 8'h7e);
    send_end_of_frame();
    // capacity reached among the silence words
    write_capacity(16'd4);
    send_pixel(8'h0f, 8'hf0, 8'h55);
    send_end_of_frame();
    // zero capacity: one word still goes out
    write_capacity(16'd0);
    send_end_of_frame();
    send_pixel(8'haa, 8'h55, 8'hcc);
    send_end_of_frame();
    // lower capacity below the count in the middle of a frame
    write_capacity(16'hffff);
    send_pixel(8'h01, 8'h02, 8'h04);
    send_pixel(8'h08, 8'h10, 8'h20);
    write_capacity(16'd2);
    send_pixel(8'h40, 8'h80, 8'hfe);
    send_end_of_frame();
  endtask

  task automatic test_input_stall();
    write_capacity(16'hffff);
    hold_arm = 1'b1;
    for (int i = 0; i < 12; i++)
      send_pixel(pick_byte(), pick_byte(), pick_byte());
    send_end_of_frame();
  endtask

  task automatic run_random_frames(input int target, input int max_len);
    int made;
    int len;
    made = 0;
    while (made < target) begin
      len = $urandom_range(0, max_len);
      for (int p = 0; p < len; p++) begin
        send_pixel(pick_byte(), pick_byte(), pick_byte());
        made++;
      end
      // occasional stray end of frame
      if ($urandom_range(0, 9) == 0) begin
        send_end_of_frame();
        made++;
      end
      send_end_of_frame();
      made++;
    end
  endtask

  task automatic test_random_frames();
    write_capacity(lpsp_pkg::CAP_RESET);
    sender_gaps = 1'b1;
    run_random_frames(ITEMS_PER_PHASE, 10);
    write_capacity(16'($urandom_range(1, 6)));
    sender_gaps = 1'b0;
    run_random_frames(ITEMS_PER_PHASE, 6);
    write_capacity(16'hffff);
    sender_gaps = 1'b1;
    run_random_frames(ITEMS_PER_PHASE, 10);
    write_capacity(16'($urandom_range(7, 40)));
    sender_gaps = 1'b0;
    run_random_frames(ITEMS_PER_PHASE, 14);
    write_capacity(16'd1);
    sender_gaps = 1'b1;
    run_random_frames(ITEMS_PER_PHASE, 3);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_words();
    test_capacity_stops();
    test_input_stall();
    test_random_frames();
    wait_idle();
    if (errors == 0 && expected_words.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== led_pixel_symbol_packer.f =====
+incdir+rtl/core
rtl/core/lpsp_pkg.sv
rtl/core/lpsp_slicer.sv
rtl/core/led_pixel_symbol_packer.sv
rtl/core/lpsp_checker.sv
tb/tb_top.sv
